[rtl/core/cfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cfe_pkg;

   localparam int unsigned FIELD_W   = 32;
   localparam int unsigned TERM_W    = 32;
   localparam int unsigned MAX_TERMS = 48;
   localparam int unsigned TCNT_W    = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EMIT,
      ST_ERR
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic next;
      logic emit;
      logic emit_err;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic den_zero;
      logic step_last;
      logic term_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/cfe_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfe_dpath #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cfe_pkg::cmd_type                    cmd,
   output cfe_pkg::status_type                      status,
   input  wire logic [cfe_pkg::FIELD_W-1:0]         numerator,
   input  wire logic [cfe_pkg::FIELD_W-1:0]         denominator,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [cfe_pkg::TERM_W-1:0]               rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tuser
);

   localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0]                 quo_ff, quo_in;
   logic [WIDTH-1:0]                 rem_ff, rem_in;
   logic [WIDTH-1:0]                 div_ff, div_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [cfe_pkg::TCNT_W-1:0]       tcnt_ff, tcnt_in;
   logic [cfe_pkg::TERM_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_err_ff, rsp_err_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [cfe_pkg::FIELD_W+WIDTH-1:0] num_ext, den_ext;
   logic [cfe_pkg::TERM_W+WIDTH-1:0]  quo_ext;
   logic [WIDTH:0]                    shifted, diff;
   logic                              fits;
   logic                              last_now;

   // fields are taken modulo 2^WIDTH, terms cut to the term field
   assign num_ext = {{WIDTH{1'b0}}, numerator};
   assign den_ext = {{WIDTH{1'b0}}, denominator};
   assign quo_ext = {{cfe_pkg::TERM_W{1'b0}}, quo_ff};

   // one restoring division step
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = ~diff[WIDTH];

   assign last_now = (rem_ff == '0) ||
                     (tcnt_ff == cfe_pkg::TCNT_W'(cfe_pkg::MAX_TERMS - 1));

   always_comb begin
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      tcnt_in      = tcnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_in  = quo_ext[cfe_pkg::TERM_W-1:0];
         rsp_last_in  = last_now;
         rsp_err_in   = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (cmd.emit_err) begin
         rsp_data_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_err_in   = 1'b1;
         rsp_valid_in = 1'b1;
      end
      if (cmd.load) begin
         quo_in  = num_ext[WIDTH-1:0];
         div_in  = den_ext[WIDTH-1:0];
         rem_in  = '0;
         cnt_in  = '0;
         tcnt_in = '0;
      end
      if (cmd.step) begin
         rem_in = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
      end
      // pair moves on to (divisor, remainder)
      if (cmd.next) begin
         quo_in  = div_ff;
         div_in  = rem_ff;
         rem_in  = '0;
         cnt_in  = '0;
         tcnt_in = tcnt_ff + cfe_pkg::TCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         tcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         tcnt_ff      <= tcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign status.den_zero  = (div_ff == '0);
   assign status.step_last = (cnt_ff == CW'(WIDTH - 1));
   assign status.term_last = last_now;
   assign status.out_free  = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_err) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result word overwritten before taken");

   a_emit_nonzero_div: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (div_ff != '0))
      else $error("term emitted with zero divisor");

   a_err_zero_div: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_err |-> (div_ff == '0))
      else $error("error word with nonzero divisor");

   a_tcnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.next |-> (tcnt_ff < cfe_pkg::TCNT_W'(cfe_pkg::MAX_TERMS - 1)))
      else $error("term count past limit");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> rsp_last_ff)
      else $error("error word not marked last");
`endif

endmodule
`default_nettype wire

[rtl/core/cfe_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module cfe_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire cfe_pkg::status_type  status,
   output cfe_pkg::cmd_type          cmd
);

   cfe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         cfe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = cfe_pkg::ST_CHECK;
            end
         end
         cfe_pkg::ST_CHECK: begin
            state_in = status.den_zero ? cfe_pkg::ST_ERR : cfe_pkg::ST_DIV;
         end
         cfe_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = cfe_pkg::ST_EMIT;
            end
         end
         cfe_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.term_last) begin
                  state_in = cfe_pkg::ST_IDLE;
               end else begin
                  cmd.next = 1'b1;
                  state_in = cfe_pkg::ST_DIV;
               end
            end
         end
         cfe_pkg::ST_ERR: begin
            if (status.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = cfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/continued_fraction_expansion.sv]
// an accepted word is checked, divided serially, then its first term is emitted
// each further term: one divide step per bit, then an emit, held while output is full
// the next word is taken only after the last term of the one before; 48 terms at most
// a zero denominator gives a single error word and no terms
// synchronous active-high reset returns the controller to idle and drops rsp_tvalid
`timescale 1ns / 1ps
`default_nettype none
module continued_fraction_expansion #(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // numerator [31:0], denominator [63:32]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // term [31:0]
   output logic              rsp_tlast,   // last_term
   output logic              rsp_tuser    // divide_error
);

   cfe_pkg::cmd_type    cmd;
   cfe_pkg::status_type status;

   cfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfe_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .numerator   (req_tdata[31:0]),
      .denominator (req_tdata[63:32]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

[test/continued_fraction_expansion_tb.sv]
`timescale 1ns / 1ps
module continued_fraction_expansion_tb;

   localparam int unsigned ITEMS      = 370;
   localparam int unsigned DRAIN      = 2 * (cfe_pkg::FIELD_W + 3) + 20;
   localparam int unsigned CYCLE_CAP  = 10_000_000;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [cfe_pkg::TERM_W-1:0] term;
      logic                       is_last;
      logic                       div_err;
   } term_word_type;

   typedef struct {
      logic [31:0]   num;
      logic [31:0]   den;
      bit            typed;
      term_word_type fixed;
   } fraction_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // numerator [31:0], denominator [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // term [31:0]
   logic        rsp_tlast;    // last_term
   logic        rsp_tuser;    // divide_error

   term_word_type terms_due[$];
   bit            fixed_word_on;
   term_word_type fixed_word;
   int unsigned   mismatches;
   int unsigned   burst_left;
   int unsigned   cycle_count;
   logic [15:0]   ready_pattern;
   int unsigned   pattern_left;

   continued_fraction_expansion uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // euclid on the pair, one word per quotient
   function automatic void expand_fraction(input logic [31:0] num, input logic [31:0] den);
      logic [cfe_pkg::FIELD_W-1:0] dividend;
      logic [cfe_pkg::FIELD_W-1:0] divisor;
      logic [cfe_pkg::FIELD_W-1:0] quo;
      logic [cfe_pkg::FIELD_W-1:0] rem;
      int                          n;
      term_word_type               w;
      dividend = num;
      divisor  = den;
      n        = 0;
      if (divisor == '0) begin
         w.term    = '0;
         w.is_last = 1'b1;
         w.div_err = 1'b1;
         terms_due.push_back(w);
         return;
      end
      forever begin
         quo       = dividend / divisor;
         rem       = dividend % divisor;
         w.term    = quo;
         w.is_last = (rem == '0) || (n == cfe_pkg::MAX_TERMS - 1);
         w.div_err = 1'b0;
         terms_due.push_back(w);
         n++;
         if (w.is_last) break;
         dividend = divisor;
         divisor  = rem;
      end
   endfunction

   function automatic logic [31:0] fibonacci(input int unsigned k);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      a = 64'd0;
      b = 64'd1;
      repeat (k) begin
         t = a + b;
         a = b;
         b = t;
      end
      return a[31:0];
   endfunction

   // bursts of words with random gaps, long ones now and then
   task automatic present_word(input logic [31:0] num, input logic [31:0] den,
                               input bit typed, input term_word_type fixed);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 600) : $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid    = 1'b1;
      req_tdata     = {den, num};
      fixed_word_on = typed;
      fixed_word    = fixed;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // receiver stall pattern, reloaded every so often
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               ready_pattern = 16'hFFFF;
            end
            1: begin
               ready_pattern = 16'($urandom) | 16'h0001;
            end
            2: begin
               ready_pattern = 16'h0001 << $urandom_range(0, 15);
            end
            default: begin
               ready_pattern = ~(16'h0001 << $urandom_range(0, 15));
            end
         endcase
         pattern_left = $urandom_range(8, 200);
      end else begin
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         pattern_left  = pattern_left - 1;
      end
      rsp_tready = ready_pattern[0];
   end

   always @(posedge clock) begin
      term_word_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (fixed_word_on) begin
               terms_due.push_back(fixed_word);
            end else begin
               expand_fraction(req_tdata[31:0], req_tdata[63:32]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (terms_due.size() == 0) begin
               $display("%t unexpected word: term %h last %b err %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = terms_due.pop_front();
               if (rsp_tdata !== want.term) begin
                  $display("%t term: expected %h actual %h", $time, want.term, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.is_last) begin
                  $display("%t last_term: expected %b actual %b",
                           $time, want.is_last, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser !== want.div_err) begin
                  $display("%t divide_error: expected %b actual %b",
                           $time, want.div_err, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      fraction_row_type dir_rows[$];
      term_word_type    none;
      logic [31:0]      num;
      logic [31:0]      den;
      int unsigned      k;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      ready_pattern = 16'hFFFF;
      pattern_left  = 0;
      fixed_word_on = 1'b0;
      fixed_word    = '0;
      none          = '0;
      mismatches    = 0;
      burst_left    = 0;
      cycle_count   = 0;

      // zero denominator, zero numerator and one-term cases are typed in
      dir_rows.push_back('{32'd5,      32'd0,      1'b1, '{32'd0, 1'b1, 1'b1}});
      dir_rows.push_back('{32'd0,      32'd0,      1'b1, '{32'd0, 1'b1, 1'b1}});
      dir_rows.push_back('{ALL_ONES,   32'd0,      1'b1, '{32'd0, 1'b1, 1'b1}});
      dir_rows.push_back('{32'd0,      32'd1,      1'b1, '{32'd0, 1'b1, 1'b0}});
      dir_rows.push_back('{32'd0,      ALL_ONES,   1'b1, '{32'd0, 1'b1, 1'b0}});
      dir_rows.push_back('{ALL_ONES,   32'd1,      1'b1, '{ALL_ONES, 1'b1, 1'b0}});
      dir_rows.push_back('{ALL_ONES,   ALL_ONES,   1'b1, '{32'd1, 1'b1, 1'b0}});
      dir_rows.push_back('{32'd1,      32'd1,      1'b1, '{32'd1, 1'b1, 1'b0}});
      dir_rows.push_back('{32'd7,      32'd7,      1'b1, '{32'd1, 1'b1, 1'b0}});
      dir_rows.push_back('{32'd84,     32'd4,      1'b1, '{32'd21, 1'b1, 1'b0}});
      // the rest go through the predictor
      dir_rows.push_back('{32'd3,          32'd7,          1'b0, none});
      dir_rows.push_back('{32'd100,        32'd37,         1'b0, none});
      dir_rows.push_back('{ALL_ONES,       32'hFFFF_FFFE,  1'b0, none});
      dir_rows.push_back('{32'd1,          ALL_ONES,       1'b0, none});
      dir_rows.push_back('{ALL_ONES,       32'd2,          1'b0, none});
      dir_rows.push_back('{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, none});
      dir_rows.push_back('{32'h5555_5555,  32'hAAAA_AAAA,  1'b0, none});
      dir_rows.push_back('{32'h8000_0000,  32'h7FFF_FFFF,  1'b0, none});
      dir_rows.push_back('{32'h8000_0001,  32'h8000_0000,  1'b0, none});
      dir_rows.push_back('{32'h1234_5678,  32'h09AB_CDEF,  1'b0, none});
      // consecutive fibonacci numbers give the longest expansion
      dir_rows.push_back('{fibonacci(47),  fibonacci(46),  1'b0, none});
      dir_rows.push_back('{fibonacci(46),  fibonacci(47),  1'b0, none});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         present_word(dir_rows[i].num, dir_rows[i].den, dir_rows[i].typed, dir_rows[i].fixed);
      end

      repeat (ITEMS) begin
         case ($urandom_range(0, 99)) inside
            [0:39]: begin
               num = $urandom;
               den = $urandom;
            end
            [40:54]: begin
               den = $urandom | 32'd1;
               num = $urandom % den;
            end
            [55:69]: begin
               num = $urandom_range(0, 255);
               den = $urandom_range(1, 255);
            end
            [70:79]: begin
               k   = $urandom_range(2, 47);
               num = fibonacci(k);
               den = fibonacci(k - 1);
               if ($urandom_range(0, 1)) begin
                  {num, den} = {den, num};
               end
            end
            [80:87]: begin
               num = $urandom;
               den = 32'd1 << $urandom_range(0, 31);
            end
            [88:93]: begin
               num = $urandom;
               den = 32'd0;
            end
            default: begin
               num = 32'd0;
               den = $urandom;
            end
         endcase
         present_word(num, den, 1'b0, none);
      end
      req_tvalid = 1'b0;

      while (terms_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
